/* hdl/vps_pkg.sv */
`timescale 1ns / 1ps

package vps_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int TIMEOUT_W = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd300;

  // register addresses
  localparam logic [CFG_ADDR_W-1:0] ADDR_TIMEOUT = 2'd0;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // valve drive patterns {common, close, open}, 0 = driven
  localparam logic [2:0] VD_RELEASED = 3'b111;
  localparam logic [2:0] VD_OPEN_DRIVEN = 3'b010;
  localparam logic [2:0] VD_CLOSE_DRIVEN = 3'b001;

  // pump drive levels
  localparam logic PUMP_ON = 1'b0;
  localparam logic PUMP_OFF = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'b0001,
    PH_PUMP_STOP  = 4'b0010,
    PH_VALVE      = 4'b0100,
    PH_PUMP_START = 4'b1000
  } phase_t;

  typedef struct packed {
    logic kind;
    logic open_request;
    logic reflux_switch;
    logic drain_open_switch;
    logic drain_close_switch;
  } item_t;

  typedef struct packed {
    logic drive_drain_open;
    logic drive_drain_close;
    logic drive_drain_common;
    logic drive_pump;
    logic busy_res;
    logic finished;
    logic success;
  } result_t;

endpackage

/* hdl/vps_cfg.sv */
`timescale 1ns / 1ps

module vps_cfg
  import vps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [TIMEOUT_W-1:0]  timeout_ticks
);

  logic wr_en;

  // write strobe for the timeout register
  assign wr_en = psel && penable && pwrite && (paddr == ADDR_TIMEOUT);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (wr_en) begin
      timeout_ticks <= pwdata[TIMEOUT_W-1:0];
    end
  end

  assign prdata = {{(CFG_DATA_W-TIMEOUT_W){1'b0}}, timeout_ticks};

endmodule

/* hdl/vps_core.sv */
`timescale 1ns / 1ps

module vps_core
  import vps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  item_t                item,
  input  logic [TIMEOUT_W-1:0] timeout_ticks,
  output result_t              result
);

  phase_t               phase, phase_next;
  logic [TIMEOUT_W-1:0] wait_count, wait_count_next;
  logic                 open_dir, open_dir_next;
  logic [2:0]           valve_drives, valve_drives_next;
  logic                 pump_drive, pump_drive_next;
  logic                 match;
  logic                 fin, ok;
  logic [TIMEOUT_W-1:0] count_inc;

  // switch check for the current wait phase
  always_comb begin
    case (phase)
      PH_PUMP_STOP:  match = item.reflux_switch;
      PH_VALVE:      match = open_dir ? !item.drain_open_switch : !item.drain_close_switch;
      PH_PUMP_START: match = !item.reflux_switch;
      default:       match = 1'b0;
    endcase
  end

  assign count_inc = wait_count + 1'b1;

  // sequencer next state
  always_comb begin
    phase_next        = phase;
    wait_count_next   = wait_count;
    open_dir_next     = open_dir;
    valve_drives_next = valve_drives;
    pump_drive_next   = pump_drive;
    fin               = 1'b0;
    ok                = 1'b0;
    if (item.kind == KIND_START) begin
      if (phase == PH_IDLE) begin
        open_dir_next   = item.open_request;
        wait_count_next = '0;
        if (item.open_request) begin
          valve_drives_next = VD_OPEN_DRIVEN;
          phase_next        = PH_VALVE;
        end else begin
          pump_drive_next = PUMP_OFF;
          phase_next      = PH_PUMP_STOP;
        end
      end
    end else if (phase != PH_IDLE) begin
      if (match) begin
        case (phase)
          PH_PUMP_STOP: begin
            valve_drives_next = open_dir ? VD_OPEN_DRIVEN : VD_CLOSE_DRIVEN;
            wait_count_next   = '0;
            phase_next        = PH_VALVE;
          end
          PH_VALVE: begin
            valve_drives_next = VD_RELEASED;
            if (open_dir) begin
              pump_drive_next = PUMP_ON;
              wait_count_next = '0;
              phase_next      = PH_PUMP_START;
            end else begin
              phase_next = PH_IDLE;
              fin        = 1'b1;
              ok         = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            fin        = 1'b1;
            ok         = 1'b1;
          end
        endcase
      end else begin
        wait_count_next = count_inc;
        // timeout, including the counter wrapping to zero
        if (count_inc >= timeout_ticks || count_inc == '0) begin
          if (phase == PH_VALVE) begin
            valve_drives_next = VD_RELEASED;
          end
          phase_next = PH_IDLE;
          fin        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      wait_count   <= '0;
      open_dir     <= 1'b0;
      valve_drives <= VD_RELEASED;
      pump_drive   <= PUMP_OFF;
    end else if (step) begin
      phase        <= phase_next;
      wait_count   <= wait_count_next;
      open_dir     <= open_dir_next;
      valve_drives <= valve_drives_next;
      pump_drive   <= pump_drive_next;
    end
  end

  // result reflects the state after this item
  assign result.drive_drain_open   = valve_drives_next[0];
  assign result.drive_drain_close  = valve_drives_next[1];
  assign result.drive_drain_common = valve_drives_next[2];
  assign result.drive_pump         = pump_drive_next;
  assign result.busy_res           = (phase_next != PH_IDLE);
  assign result.finished           = fin;
  assign result.success            = ok;

endmodule

/* hdl/valve_pump_sequencer.sv */
`timescale 1ns / 1ps

// Pipeline: an accepted item waits in the input register, and its result is then held in the
// result register; while the result register is full and stalled, the item waits.
// Throughput: one item per cycle when the output does not stall; the sequencer state updates as an
// item leaves the input register, and an output stall on a full result register stalls the input.
// Reset (synchronous, active high): idle, valve released, pump off, timeout 300 ticks,
// both pipeline registers empty.
module valve_pump_sequencer
  import vps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  item_t                 in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output result_t               out_result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                 in_valid_q;
  item_t                item_q;
  logic                 out_free;
  logic                 advance;
  logic [TIMEOUT_W-1:0] timeout_ticks;
  result_t              result;

  vps_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .timeout_ticks (timeout_ticks)
  );

  vps_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (item_q),
    .timeout_ticks (timeout_ticks),
    .result        (result)
  );

  // pipeline flow control
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_valid_q && out_free;
  assign in_stall = in_valid_q && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_q <= in_item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  // checks
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register is free");

  a_success_needs_finish: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.success) |-> out_result.finished)
    else $error("success reported without finished");

  a_finish_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.finished) |-> !out_result.busy_res)
    else $error("finished while still busy");

  a_idle_valve_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_result.busy_res) |->
      (out_result.drive_drain_open && out_result.drive_drain_close &&
       out_result.drive_drain_common))
    else $error("valve driven while idle");

endmodule
